// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by rgb_pixel_effect_chain_unit
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);
`else
`define PFX_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/pfx_pkg.sv -----
// shared types, constants and arithmetic helpers of the pixel effect chain
// no dependencies
package pfx_pkg;

  // channel order inside a pixel word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int NUM_CH   = 3;

  typedef logic [NUM_CH-1:0][7:0] chan3_t;

  // effect enable bit positions
  localparam int EN_INVERT   = 0;
  localparam int EN_MONO     = 1;
  localparam int EN_MONO_THR = 2;
  localparam int EN_QUANT    = 3;
  localparam int EN_EXPOSURE = 4;
  localparam int EN_CONTRAST = 5;
  localparam int EN_SAT      = 6;
  localparam int EN_BIAS     = 7;
  localparam int EN_SHIFT    = 8;

  // register indexes
  localparam logic [2:0] REG_EFFECT_ENABLES  = 3'd0;
  localparam logic [2:0] REG_MONO_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_QUANT_BITS      = 3'd2;
  localparam logic [2:0] REG_EXPOSURE_GAIN   = 3'd3;
  localparam logic [2:0] REG_CONTRAST_STEP   = 3'd4;
  localparam logic [2:0] REG_SATURATION_GAIN = 3'd5;
  localparam logic [2:0] REG_BIAS_CHANNEL    = 3'd6;
  localparam logic [2:0] REG_SHIFT_AMOUNT    = 3'd7;

  localparam logic [1:0] BIAS_NONE = 2'd3;

  // contrast decision points
  localparam logic [7:0] DARK_LIMIT   = 8'd100;
  localparam logic [7:0] BRIGHT_LIMIT = 8'd140;

  // quantize rescale: v * factor >> QUANT_FRAC
  localparam int QUANT_FRAC = 17;

  typedef struct packed {
    logic [8:0]  effect_enables;
    logic [7:0]  mono_threshold;
    logic [3:0]  quant_bits;
    logic [11:0] exposure_gain;
    logic [7:0]  contrast_step;
    logic [11:0] saturation_gain;
    logic [1:0]  bias_channel;
    logic [8:0]  shift_amount;
  } cfg_t;

  // sum of three channels, at most 765
  function automatic logic [9:0] sum3(input chan3_t c);
    return {2'b00, c[CH_RED]} + {2'b00, c[CH_GREEN]} + {2'b00, c[CH_BLUE]};
  endfunction

  // floor(s / 3) for s <= 765 by reciprocal multiply
  function automatic logic [7:0] div3_sum(input logic [9:0] s);
    logic [20:0] p;
    p = {11'd0, s} * 21'd683;
    return p[18:11];
  endfunction

  // floor(c / 3) for one channel
  function automatic logic [7:0] div3_chan(input logic [7:0] c);
    logic [16:0] p;
    p = {9'd0, c} * 17'd171;
    return p[16:9];
  endfunction

  // ceil(255 * 2^17 / (2^q - 1)) for q of 1 to 8
  function automatic logic [24:0] quant_factor(input logic [3:0] q);
    logic [24:0] f;
    case (q)
      4'd1:    f = 25'd33423360;
      4'd2:    f = 25'd11141120;
      4'd3:    f = 25'd4774766;
      4'd4:    f = 25'd2228224;
      4'd5:    f = 25'd1078173;
      4'd6:    f = 25'd530530;
      4'd7:    f = 25'd263177;
      default: f = 25'd131072;
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/rgb_pixel_effect_chain_unit.sv -----
// rgb pixel effect chain: 14 register stages, one pixel word accepted every cycle
// throughput: one word per cycle, busy is never raised; the receiver cannot stall
// rst (synchronous, active high) empties the pipeline and loads the register defaults
// depends on pfx_pkg, pfx_tone, pfx_level, pfx_sat, pfx_mix, assert_macros.svh
`include "assert_macros.svh"

module rgb_pixel_effect_chain_unit (
  input  logic        clk,
  input  logic        rst,
  // pixel in
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  // pixel out, one cycle strobe
  output logic        done,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  // register writes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  pfx_pkg::cfg_t   cfg;

  logic            accept;
  pfx_pkg::chan3_t in_pix;

  logic            tone_valid;
  pfx_pkg::chan3_t tone_pix;
  logic            level_valid;
  pfx_pkg::chan3_t level_pix;
  logic            sat_valid;
  pfx_pkg::chan3_t sat_pix;
  logic            mix_valid;
  pfx_pkg::chan3_t mix_pix;

  // every stage advances every cycle, so the chain is always open
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    in_pix[pfx_pkg::CH_RED]   = red_in;
    in_pix[pfx_pkg::CH_GREEN] = green_in;
    in_pix[pfx_pkg::CH_BLUE]  = blue_in;
  end

  // register file; values are masked to the register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_enables  <= 9'd0;
      cfg.mono_threshold  <= 8'd120;
      cfg.quant_bits      <= 4'd8;
      cfg.exposure_gain   <= 12'd256;
      cfg.contrast_step   <= 8'd0;
      cfg.saturation_gain <= 12'd256;
      cfg.bias_channel    <= pfx_pkg::BIAS_NONE;
      cfg.shift_amount    <= 9'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        pfx_pkg::REG_EFFECT_ENABLES:  cfg.effect_enables  <= cfg_data[8:0];
        pfx_pkg::REG_MONO_THRESHOLD:  cfg.mono_threshold  <= cfg_data[7:0];
        pfx_pkg::REG_QUANT_BITS:      cfg.quant_bits      <= cfg_data[3:0];
        pfx_pkg::REG_EXPOSURE_GAIN:   cfg.exposure_gain   <= cfg_data[11:0];
        pfx_pkg::REG_CONTRAST_STEP:   cfg.contrast_step   <= cfg_data[7:0];
        pfx_pkg::REG_SATURATION_GAIN: cfg.saturation_gain <= cfg_data[11:0];
        pfx_pkg::REG_BIAS_CHANNEL:    cfg.bias_channel    <= cfg_data[1:0];
        pfx_pkg::REG_SHIFT_AMOUNT:    cfg.shift_amount    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // invert, mono, quantize (4 stages)
  pfx_tone u_tone (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (accept),
    .in_pix    (in_pix),
    .out_valid (tone_valid),
    .out_pix   (tone_pix)
  );

  // exposure, contrast (3 stages)
  pfx_level u_level (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (tone_valid),
    .in_pix    (tone_pix),
    .out_valid (level_valid),
    .out_pix   (level_pix)
  );

  // saturation (4 stages)
  pfx_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (level_valid),
    .in_pix    (level_pix),
    .out_valid (sat_valid),
    .out_pix   (sat_pix)
  );

  // bias, color rotate; last stage is the output register (3 stages)
  pfx_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sat_valid),
    .in_pix    (sat_pix),
    .out_valid (mix_valid),
    .out_pix   (mix_pix)
  );

  assign done      = mix_valid;
  assign red_out   = mix_pix[pfx_pkg::CH_RED];
  assign green_out = mix_pix[pfx_pkg::CH_GREEN];
  assign blue_out  = mix_pix[pfx_pkg::CH_BLUE];

  // every accepted word comes out after the fixed latency, and nothing else does
  `PFX_ASSERT_IMPL(a_word_delivered, clk, rst, start && !busy, ##14 done, "accepted word not delivered")
  `PFX_ASSERT_IMPL(a_word_origin, clk, rst, done, $past(start && !busy, 14), "word without an accept")
  `PFX_ASSERT_NEXT(a_valid_chain, clk, rst, sat_valid, ##2 done, "word lost in the mix stages")

endmodule

// ----- hw/rtl/pfx_tone.sv -----
// invert, mono with threshold, and quantize: four register stages
// depends on pfx_pkg
module pfx_tone (
  input  logic             clk,
  input  logic             rst,
  input  pfx_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  pfx_pkg::chan3_t  in_pix,
  output logic             out_valid,
  output pfx_pkg::chan3_t  out_pix
);

  logic [3:0] valid;

  pfx_pkg::chan3_t s1_pix;
  logic [9:0]      s1_sum;
  pfx_pkg::chan3_t s2_pix;
  pfx_pkg::chan3_t s3_pix;
  logic [pfx_pkg::NUM_CH-1:0][32:0] s3_prod;
  pfx_pkg::chan3_t s4_pix;

  pfx_pkg::chan3_t inv_pix;
  pfx_pkg::chan3_t mono_pix;
  logic [7:0]      luma;
  logic [3:0]      qc;
  logic [3:0]      qshift;
  logic [24:0]     qfac;
  logic [pfx_pkg::NUM_CH-1:0][32:0] qprod;
  pfx_pkg::chan3_t quant_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], in_valid};
    end
  end

  // invert
  always_comb begin
    inv_pix = cfg.effect_enables[pfx_pkg::EN_INVERT] ? ~in_pix : in_pix;
  end

  // mono
  always_comb begin
    luma = pfx_pkg::div3_sum(s1_sum);
    if (cfg.effect_enables[pfx_pkg::EN_MONO_THR]) begin
      luma = (luma > cfg.mono_threshold) ? 8'd255 : 8'd0;
    end
    if (cfg.effect_enables[pfx_pkg::EN_MONO]) begin
      mono_pix = {pfx_pkg::NUM_CH{luma}};
    end else begin
      mono_pix = s1_pix;
    end
  end

  // quantize: keep q top bits, rescale to full range
  always_comb begin
    if (cfg.quant_bits == 4'd0) begin
      qc = 4'd1;
    end else if (cfg.quant_bits > 4'd8) begin
      qc = 4'd8;
    end else begin
      qc = cfg.quant_bits;
    end
    qshift = 4'd8 - qc;
    qfac   = pfx_pkg::quant_factor(qc);
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      qprod[i] = {25'd0, s2_pix[i] >> qshift[2:0]} * {8'd0, qfac};
    end
  end

  always_comb begin
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      quant_pix[i] = cfg.effect_enables[pfx_pkg::EN_QUANT]
                     ? s3_prod[i][pfx_pkg::QUANT_FRAC+7:pfx_pkg::QUANT_FRAC] : s3_pix[i];
    end
  end

  always_ff @(posedge clk) begin
    s1_pix  <= inv_pix;
    s1_sum  <= pfx_pkg::sum3(inv_pix);
    s2_pix  <= mono_pix;
    s3_pix  <= s2_pix;
    s3_prod <= qprod;
    s4_pix  <= quant_pix;
  end

  assign out_valid = valid[3];
  assign out_pix   = s4_pix;

endmodule

// ----- hw/rtl/pfx_level.sv -----
// exposure gain and contrast step: three register stages
// depends on pfx_pkg
module pfx_level (
  input  logic             clk,
  input  logic             rst,
  input  pfx_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  pfx_pkg::chan3_t  in_pix,
  output logic             out_valid,
  output pfx_pkg::chan3_t  out_pix
);

  logic [2:0] valid;

  pfx_pkg::chan3_t s1_pix;
  logic [pfx_pkg::NUM_CH-1:0][19:0] s1_prod;
  pfx_pkg::chan3_t s2_pix;
  logic [9:0]      s2_sum;
  pfx_pkg::chan3_t s3_pix;

  logic [pfx_pkg::NUM_CH-1:0][19:0] eprod;
  pfx_pkg::chan3_t exp_pix;
  pfx_pkg::chan3_t con_pix;
  logic [7:0]      avg;
  logic [8:0]      up;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      eprod[i] = {12'd0, in_pix[i]} * {8'd0, cfg.exposure_gain};
    end
  end

  // exposure saturates at full scale
  always_comb begin
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      if (!cfg.effect_enables[pfx_pkg::EN_EXPOSURE]) begin
        exp_pix[i] = s1_pix[i];
      end else if (s1_prod[i][19:16] != 4'd0) begin
        exp_pix[i] = 8'd255;
      end else begin
        exp_pix[i] = s1_prod[i][15:8];
      end
    end
  end

  // contrast: step down when dark, up when bright
  always_comb begin
    avg     = pfx_pkg::div3_sum(s2_sum);
    up      = '0;
    con_pix = s2_pix;
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      up = {1'b0, s2_pix[i]} + {1'b0, cfg.contrast_step};
      if (cfg.effect_enables[pfx_pkg::EN_CONTRAST]) begin
        if (avg <= pfx_pkg::DARK_LIMIT) begin
          con_pix[i] = (s2_pix[i] > cfg.contrast_step) ? s2_pix[i] - cfg.contrast_step : 8'd0;
        end else if (avg > pfx_pkg::BRIGHT_LIMIT) begin
          con_pix[i] = up[8] ? 8'd255 : up[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pix  <= in_pix;
    s1_prod <= eprod;
    s2_pix  <= exp_pix;
    s2_sum  <= pfx_pkg::sum3(exp_pix);
    s3_pix  <= con_pix;
  end

  assign out_valid = valid[2];
  assign out_pix   = s3_pix;

endmodule

// ----- hw/rtl/pfx_sat.sv -----
// saturation gain about the gray value: four register stages
// depends on pfx_pkg
module pfx_sat (
  input  logic             clk,
  input  logic             rst,
  input  pfx_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  pfx_pkg::chan3_t  in_pix,
  output logic             out_valid,
  output pfx_pkg::chan3_t  out_pix
);

  logic [3:0] valid;

  pfx_pkg::chan3_t s1_pix;
  logic [9:0]      s1_sum;
  pfx_pkg::chan3_t s2_pix;
  pfx_pkg::chan3_t s2_mag;
  logic [pfx_pkg::NUM_CH-1:0] s2_above;
  logic [7:0]      s2_gray;
  pfx_pkg::chan3_t s3_pix;
  logic [pfx_pkg::NUM_CH-1:0][19:0] s3_prod;
  logic [pfx_pkg::NUM_CH-1:0] s3_above;
  logic [7:0]      s3_gray;
  pfx_pkg::chan3_t s4_pix;

  logic [7:0]      gray;
  pfx_pkg::chan3_t mag;
  logic [pfx_pkg::NUM_CH-1:0] above;
  logic [pfx_pkg::NUM_CH-1:0][19:0] sprod;
  pfx_pkg::chan3_t sat_pix;
  logic [11:0]     t;
  logic [12:0]     hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], in_valid};
    end
  end

  // distance of each channel from gray
  always_comb begin
    gray = pfx_pkg::div3_sum(s1_sum);
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      above[i] = s1_pix[i] >= gray;
      mag[i]   = above[i] ? s1_pix[i] - gray : gray - s1_pix[i];
    end
  end

  always_comb begin
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      sprod[i] = {12'd0, s2_mag[i]} * {8'd0, cfg.saturation_gain};
    end
  end

  // scaled distance back onto gray, clamped
  always_comb begin
    t  = '0;
    hi = '0;
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      t  = s3_prod[i][19:8];
      hi = {5'd0, s3_gray} + {1'b0, t};
      if (!cfg.effect_enables[pfx_pkg::EN_SAT]) begin
        sat_pix[i] = s3_pix[i];
      end else if (s3_above[i]) begin
        sat_pix[i] = (hi > 13'd255) ? 8'd255 : hi[7:0];
      end else if (t > {4'd0, s3_gray}) begin
        sat_pix[i] = 8'd0;
      end else begin
        sat_pix[i] = s3_gray - t[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pix   <= in_pix;
    s1_sum   <= pfx_pkg::sum3(in_pix);
    s2_pix   <= s1_pix;
    s2_mag   <= mag;
    s2_above <= above;
    s2_gray  <= gray;
    s3_pix   <= s2_pix;
    s3_prod  <= sprod;
    s3_above <= s2_above;
    s3_gray  <= s2_gray;
    s4_pix   <= sat_pix;
  end

  assign out_valid = valid[3];
  assign out_pix   = s4_pix;

endmodule

// ----- hw/rtl/pfx_mix.sv -----
// channel bias and color rotate blend: three register stages
// depends on pfx_pkg
module pfx_mix (
  input  logic             clk,
  input  logic             rst,
  input  pfx_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  pfx_pkg::chan3_t  in_pix,
  output logic             out_valid,
  output pfx_pkg::chan3_t  out_pix
);

  logic [2:0] valid;

  pfx_pkg::chan3_t s1_pix;
  pfx_pkg::chan3_t s2_pix;
  logic [pfx_pkg::NUM_CH-1:0][16:0] s2_pw;
  logic [pfx_pkg::NUM_CH-1:0][16:0] s2_ps;
  pfx_pkg::chan3_t s3_pix;

  pfx_pkg::chan3_t bias_pix;
  logic [8:0]      w;
  logic [8:0]      iw;
  logic [pfx_pkg::NUM_CH-1:0][16:0] pw;
  logic [pfx_pkg::NUM_CH-1:0][16:0] ps;
  logic [7:0]      other;
  pfx_pkg::chan3_t blend_pix;
  logic [17:0]     bsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  // bias: channels other than the kept one drop to a third
  always_comb begin
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      if (cfg.effect_enables[pfx_pkg::EN_BIAS] && cfg.bias_channel != pfx_pkg::BIAS_NONE &&
          cfg.bias_channel != 2'(i)) begin
        bias_pix[i] = pfx_pkg::div3_chan(in_pix[i]);
      end else begin
        bias_pix[i] = in_pix[i];
      end
    end
  end

  // blend weights; small weight mixes in the previous channel, large the next
  always_comb begin
    w     = (cfg.shift_amount > 9'd256) ? 9'd256 : cfg.shift_amount;
    iw    = 9'd256 - w;
    other = '0;
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      if (w <= 9'd128) begin
        other = s1_pix[(i == 0) ? pfx_pkg::NUM_CH - 1 : i - 1];
      end else begin
        other = s1_pix[(i == pfx_pkg::NUM_CH - 1) ? 0 : i + 1];
      end
      pw[i] = {8'd0, w} * {9'd0, other};
      ps[i] = {8'd0, iw} * {9'd0, s1_pix[i]};
    end
  end

  always_comb begin
    bsum = '0;
    for (int i = 0; i < pfx_pkg::NUM_CH; i++) begin
      bsum = {1'b0, s2_pw[i]} + {1'b0, s2_ps[i]};
      blend_pix[i] = cfg.effect_enables[pfx_pkg::EN_SHIFT] ? bsum[15:8] : s2_pix[i];
    end
  end

  always_ff @(posedge clk) begin
    s1_pix <= bias_pix;
    s2_pix <= s1_pix;
    s2_pw  <= pw;
    s2_ps  <= ps;
    s3_pix <= blend_pix;
  end

  assign out_valid = valid[2];
  assign out_pix   = s3_pix;

endmodule
